// ===== rtl/wdm_pkg.sv =====
// shared types and constants of the watchdog monitor
`default_nettype none

package wdm_pkg;

    localparam int WDM_MAX_SLOTS = 16;

    localparam int SLOT_FIELD_W = 4;
    localparam int TIME_W       = 32;
    localparam int COUNT_W      = 5;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = 1;
    localparam int CMDQ_CNT_W = 2;

    localparam logic [1:0] OP_REGISTER   = 2'd0;
    localparam logic [1:0] OP_TOUCH      = 2'd1;
    localparam logic [1:0] OP_UNREGISTER = 2'd2;
    localparam logic [1:0] OP_CHECK      = 2'd3;

    localparam logic [1:0] CFG_MISS_LIMIT       = 2'd0;
    localparam logic [1:0] CFG_MEGA_MISS_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_KILL_LIMIT       = 2'd2;
    localparam logic [1:0] CFG_MULTI_KILL_LIMIT = 2'd3;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [TIME_W-1:0]       now_time;
    } req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] miss_count;
        logic [COUNT_W-1:0] mega_miss_count;
        logic               kill;
        logic               multi_kill;
        logic               halted;
        logic [TIME_W-1:0]  miss_total;
        logic [TIME_W-1:0]  mega_miss_total;
    } rsp_t;

    typedef struct packed {
        logic [1:0]              op;
        logic                    in_range;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [TIME_W-1:0]       now_time;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/wdm_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module wdm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/wdm_front.sv =====
// front end: accepts request words, classifies them and queues commands
`default_nettype none

module wdm_front
    import wdm_pkg::*;
#(
    parameter int MAX_SLOTS = WDM_MAX_SLOTS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic      full,
    input  req_t      req,
    output logic      cmd_valid,
    output cmd_t      cmd,
    input  wire logic cmd_take
);

    cmd_t                  q_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  do_push;
    logic                  do_pop;
    cmd_t                  cls;

    assign full      = (cnt_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        cls.op       = req.req_type;
        cls.in_range = ({5'd0, req.slot} < 9'(MAX_SLOTS));
        cls.slot     = req.slot;
        cls.now_time = req.now_time;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wdm_back.sv =====
// back end: slot table, limit registers, check scan and result register
`default_nettype none

module wdm_back
    import wdm_pkg::*;
#(
    parameter int MAX_SLOTS = WDM_MAX_SLOTS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        cmd_valid,
    input  cmd_t             cmd,
    output logic             cmd_take,
    output logic             empty,
    input  wire logic        pop,
    output rsp_t             rsp
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [MAX_SLOTS-1:0] active_reg, active_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 eval_vld_reg, eval_vld_next;
    logic [SLOT_W-1:0]    eval_idx_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [COUNT_W-1:0]   miss_cnt_reg, miss_cnt_next;
    logic [COUNT_W-1:0]   mega_cnt_reg, mega_cnt_next;
    logic                 kill_reg, kill_next;
    logic [1:0]           mk_reg, mk_next;
    logic                 halt_reg, halt_next;
    logic [TIME_W-1:0]    miss_tot_reg, miss_tot_next;
    logic [TIME_W-1:0]    mega_tot_reg, mega_tot_next;
    logic                 res_valid_reg, res_valid_next;
    rsp_t                 res_reg, res_next;
    logic [31:0]          miss_lim_reg, mega_lim_reg, kill_lim_reg, mk_lim_reg;

    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [TIME_W-1:0]    ram_rdata;
    logic                 issue;
    logic                 hit;
    logic [TIME_W-1:0]    delta;

    assign cmd_take  = (state_reg == ST_IDLE) && cmd_valid && !res_valid_reg;
    assign empty     = !res_valid_reg;
    assign rsp       = res_reg;
    assign ram_we    = cmd_take && cmd.in_range
                       && (cmd.op == OP_REGISTER || cmd.op == OP_TOUCH);
    assign ram_waddr = SLOT_W'(cmd.slot);
    assign ram_raddr = cnt_reg[SLOT_W-1:0];
    assign issue     = (state_reg == ST_SCAN) && (cnt_reg < CNT_W'(MAX_SLOTS));
    assign hit       = eval_vld_reg && active_reg[eval_idx_reg];
    assign delta     = now_reg - ram_rdata;

    wdm_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_SLOTS),
        .AW    (SLOT_W)
    ) u_touch_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.now_time),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        cnt_next       = cnt_reg;
        eval_vld_next  = issue;
        miss_cnt_next  = miss_cnt_reg;
        mega_cnt_next  = mega_cnt_reg;
        kill_next      = kill_reg;
        mk_next        = mk_reg;
        halt_next      = halt_reg;
        miss_tot_next  = miss_tot_reg;
        mega_tot_next  = mega_tot_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        if (pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end

        // per-slot evaluation of data read in the previous cycle
        if (hit)
        begin
            if (delta > miss_lim_reg)
            begin
                miss_cnt_next = miss_cnt_reg + 1'b1;
                miss_tot_next = miss_tot_reg + 1'b1;
            end
            if (delta > mega_lim_reg)
            begin
                mega_cnt_next = mega_cnt_reg + 1'b1;
                mega_tot_next = mega_tot_reg + 1'b1;
            end
            if (kill_lim_reg != '0 && delta > kill_lim_reg)
            begin
                kill_next = 1'b1;
            end
            if (mk_lim_reg != '0 && delta > mk_lim_reg && mk_reg != 2'd2)
            begin
                mk_next = mk_reg + 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    if (cmd.op == OP_CHECK)
                    begin
                        state_next    = ST_SCAN;
                        cnt_next      = '0;
                        miss_cnt_next = '0;
                        mega_cnt_next = '0;
                        kill_next     = 1'b0;
                        mk_next       = '0;
                    end
                    else
                    begin
                        if (cmd.in_range && cmd.op == OP_REGISTER)
                        begin
                            active_next[SLOT_W'(cmd.slot)] = 1'b1;
                        end
                        if (cmd.in_range && cmd.op == OP_UNREGISTER)
                        begin
                            active_next[SLOT_W'(cmd.slot)] = 1'b0;
                        end
                        res_next.miss_count      = '0;
                        res_next.mega_miss_count = '0;
                        res_next.kill            = 1'b0;
                        res_next.multi_kill      = 1'b0;
                        res_next.halted          = halt_reg;
                        res_next.miss_total      = miss_tot_reg;
                        res_next.mega_miss_total = mega_tot_reg;
                        res_valid_next           = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                halt_next                = halt_reg || kill_reg || (mk_reg == 2'd2);
                res_next.miss_count      = miss_cnt_reg;
                res_next.mega_miss_count = mega_cnt_reg;
                res_next.kill            = kill_reg;
                res_next.multi_kill      = (mk_reg == 2'd2);
                res_next.halted          = halt_reg || kill_reg || (mk_reg == 2'd2);
                res_next.miss_total      = miss_tot_reg;
                res_next.mega_miss_total = mega_tot_reg;
                res_valid_next           = 1'b1;
                state_next               = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            cnt_reg       <= '0;
            eval_vld_reg  <= 1'b0;
            miss_cnt_reg  <= '0;
            mega_cnt_reg  <= '0;
            kill_reg      <= 1'b0;
            mk_reg        <= '0;
            halt_reg      <= 1'b0;
            miss_tot_reg  <= '0;
            mega_tot_reg  <= '0;
            res_valid_reg <= 1'b0;
            miss_lim_reg  <= 32'd200;
            mega_lim_reg  <= 32'd1000;
            kill_lim_reg  <= '0;
            mk_lim_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            cnt_reg       <= cnt_next;
            eval_vld_reg  <= eval_vld_next;
            miss_cnt_reg  <= miss_cnt_next;
            mega_cnt_reg  <= mega_cnt_next;
            kill_reg      <= kill_next;
            mk_reg        <= mk_next;
            halt_reg      <= halt_next;
            miss_tot_reg  <= miss_tot_next;
            mega_tot_reg  <= mega_tot_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MISS_LIMIT:       miss_lim_reg <= cfg_data;
                    CFG_MEGA_MISS_LIMIT:  mega_lim_reg <= cfg_data;
                    CFG_KILL_LIMIT:       kill_lim_reg <= cfg_data;
                    CFG_MULTI_KILL_LIMIT: mk_lim_reg   <= cfg_data;
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        eval_idx_reg <= cnt_reg[SLOT_W-1:0];
        if (cmd_take)
        begin
            now_reg <= cmd.now_time;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/multi_thread_watchdog_monitor.sv =====
// top level of the multi-slot watchdog monitor
`default_nettype none

// Watchdog monitor over MAX_SLOTS watched slots. Request words (register,
// touch, unregister, check) enter through a two-word command queue, so push
// is taken while the back end is busy or a result waits; each request gives
// exactly one result word. Register, touch and unregister set their result
// when taken from the queue head; in a check the scan reads one last-touch
// entry per cycle from the last-touch table and compares its elapsed time
// against the four limits. The back end takes the next command once the
// previous result has been popped. The user must write the limit registers
// via cfg_we/cfg_index/cfg_data only while idle, not enforced by the block.

module multi_thread_watchdog_monitor
    import wdm_pkg::*;
#(
    parameter int MAX_SLOTS = WDM_MAX_SLOTS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        push,
    output logic             full,
    input  req_t             req,
    output logic             empty,
    input  wire logic        pop,
    output rsp_t             rsp
);

    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;

    wdm_front #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    wdm_back #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ===== tb/sv/multi_thread_watchdog_monitor_test.sv =====
// testbench for the multi-slot watchdog monitor: directed table, random phases, self-checking
module multi_thread_watchdog_monitor_test
    import wdm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit                 is_cfg;
        logic [3:0][31:0]   lims;
        req_t               w;
        bit                 fixed;
        rsp_t               r;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_MISS_LIMIT;
    logic [31:0] cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    req_t        req = '0;
    logic        empty;
    logic        pop = 1'b0;
    rsp_t        rsp;

    logic        row_fixed = 1'b0;
    rsp_t        row_rsp = '0;
    bit          push_up = 1'b0;
    bit          calm = 1'b0;

    // predictor state
    logic [31:0] touch_time [WDM_MAX_SLOTS];
    bit          slot_live [WDM_MAX_SLOTS];
    logic [31:0] miss_sum = '0;
    logic [31:0] mega_sum = '0;
    bit          halt_seen = 1'b0;
    logic [31:0] lim_miss = 32'd200;
    logic [31:0] lim_mega = 32'd1000;
    logic [31:0] lim_kill = '0;
    logic [31:0] lim_multi = '0;

    rsp_t        expected_q [$];
    plan_row_t   plan [$];
    int          errors = 0;
    int          n_words = 0;
    int          n_checks = 0;
    int          n_kill = 0;
    int          n_multi = 0;
    int          n_settings = 0;

    multi_thread_watchdog_monitor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .req       (req),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    initial
    begin
        for (int i = 0; i < WDM_MAX_SLOTS; i++)
        begin
            touch_time[i] = '0;
            slot_live[i] = 1'b0;
        end
    end

    function automatic rsp_t watchdog_step(req_t w);
        rsp_t        r;
        logic [31:0] gap;
        int          misses;
        int          megas;
        int          multis;
        bit          kill_hit;
        r = '0;
        misses = 0;
        megas = 0;
        multis = 0;
        kill_hit = 1'b0;
        if (w.req_type == OP_CHECK)
        begin
            for (int i = 0; i < WDM_MAX_SLOTS; i++)
            begin
                if (slot_live[i])
                begin
                    gap = w.now_time - touch_time[i];
                    if (gap > lim_miss)
                        misses++;
                    if (gap > lim_mega)
                        megas++;
                    if (lim_kill != 0 && gap > lim_kill)
                        kill_hit = 1'b1;
                    if (lim_multi != 0 && gap > lim_multi)
                        multis++;
                end
            end
            miss_sum += 32'(misses);
            mega_sum += 32'(megas);
            r.miss_count = misses[COUNT_W-1:0];
            r.mega_miss_count = megas[COUNT_W-1:0];
            r.kill = kill_hit;
            r.multi_kill = (multis >= 2);
            if (r.kill || r.multi_kill)
                halt_seen = 1'b1;
        end
        else if (w.slot < WDM_MAX_SLOTS)
        begin
            case (w.req_type)
                OP_REGISTER:
                begin
                    slot_live[w.slot] = 1'b1;
                    touch_time[w.slot] = w.now_time;
                end
                OP_TOUCH:
                    touch_time[w.slot] = w.now_time;
                default:
                    slot_live[w.slot] = 1'b0;
            endcase
        end
        r.halted = halt_seen;
        r.miss_total = miss_sum;
        r.mega_miss_total = mega_sum;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        rsp_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MISS_LIMIT:      lim_miss = cfg_data;
                    CFG_MEGA_MISS_LIMIT: lim_mega = cfg_data;
                    CFG_KILL_LIMIT:      lim_kill = cfg_data;
                    CFG_MULTI_KILL_LIMIT: lim_multi = cfg_data;
                endcase
            end
            if (pop && !empty)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("miss_count", want.miss_count, rsp.miss_count);
                    check_field("mega_miss_count", want.mega_miss_count, rsp.mega_miss_count);
                    check_field("kill", want.kill, rsp.kill);
                    check_field("multi_kill", want.multi_kill, rsp.multi_kill);
                    check_field("halted", want.halted, rsp.halted);
                    check_field("miss_total", want.miss_total, rsp.miss_total);
                    check_field("mega_miss_total", want.mega_miss_total, rsp.mega_miss_total);
                    if (want.kill)
                        n_kill++;
                    if (want.multi_kill)
                        n_multi++;
                end
            end
            if (push && !full)
            begin
                want = watchdog_step(req);
                if (row_fixed)
                    want = row_rsp;
                expected_q = {expected_q, want};
                n_words++;
                if (req.req_type == OP_CHECK)
                    n_checks++;
            end
        end
    end

    function automatic void plan_req(logic [1:0] op, logic [3:0] s, logic [31:0] t);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.lims = '0;
        row.w.req_type = op;
        row.w.slot = s;
        row.w.now_time = t;
        row.fixed = 1'b0;
        row.r = '0;
        plan = {plan, row};
    endfunction

    function automatic void plan_fixed(logic [1:0] op, logic [3:0] s, logic [31:0] t,
                                       int mc, int mm, bit k, bit mk, bit h,
                                       logic [31:0] mt, logic [31:0] mmt);
        plan_req(op, s, t);
        plan[$].fixed = 1'b1;
        plan[$].r.miss_count = mc[COUNT_W-1:0];
        plan[$].r.mega_miss_count = mm[COUNT_W-1:0];
        plan[$].r.kill = k;
        plan[$].r.multi_kill = mk;
        plan[$].r.halted = h;
        plan[$].r.miss_total = mt;
        plan[$].r.mega_miss_total = mmt;
    endfunction

    function automatic void plan_cfg(logic [31:0] miss, logic [31:0] mega,
                                     logic [31:0] kill_at, logic [31:0] multi_at);
        plan_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.lims = {multi_at, kill_at, mega, miss};
        plan = {plan, row};
    endfunction

    function automatic logic [31:0] pick_limit(int unsigned hi);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom_range(0, hi);
        endcase
    endfunction

    task automatic send_req(req_t w, bit fixed, rsp_t r);
        req <= w;
        row_fixed <= fixed;
        row_rsp <= r;
        push <= 1'b1;
        push_up = 1'b1;
        do
            @(posedge clk);
        while (full);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            push_up = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // stop sending and wait for every result to come back
    task automatic settle();
        if (push_up)
        begin
            push <= 1'b0;
            push_up = 1'b0;
        end
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_limits(logic [3:0][31:0] lims);
        logic [3:0][1:0] order;
        order = {CFG_MULTI_KILL_LIMIT, CFG_KILL_LIMIT, CFG_MEGA_MISS_LIMIT, CFG_MISS_LIMIT};
        settle();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= order[i];
            cfg_data <= lims[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    initial
    begin : stimulus
        req_t             w;
        logic [31:0]      wall;
        logic [3:0][31:0] lims;
        int               roll;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits: miss 200, mega 1000, kill and multi-kill off
        plan_fixed(OP_CHECK, 4'd0, 32'd0, 0, 0, 0, 0, 0, 0, 0);
        plan_fixed(OP_REGISTER, 4'd0, 32'd0, 0, 0, 0, 0, 0, 0, 0);
        plan_fixed(OP_CHECK, 4'd0, 32'd200, 0, 0, 0, 0, 0, 0, 0);
        plan_fixed(OP_CHECK, 4'd0, 32'd201, 1, 0, 0, 0, 0, 1, 0);
        plan_fixed(OP_CHECK, 4'd0, 32'd1001, 1, 1, 0, 0, 0, 2, 1);
        plan_fixed(OP_REGISTER, 4'd15, 32'hFFFF_FF00, 0, 0, 0, 0, 0, 2, 1);
        // elapsed time wraps past zero
        plan_fixed(OP_CHECK, 4'd0, 32'h10, 1, 0, 0, 0, 0, 3, 1);
        plan_req(OP_TOUCH, 4'd5, 32'd5);
        plan_req(OP_UNREGISTER, 4'd7, 32'hA5A5_A5A5);
        plan_req(OP_REGISTER, 4'd0, 32'hFFFF_FFFF);
        plan_req(OP_UNREGISTER, 4'd15, 32'd0);
        plan_req(OP_CHECK, 4'd9, 32'hFFFF_FFFF);
        plan_cfg(32'd0, 32'hFFFF_FFFF, 32'd500, 32'd300);
        plan_req(OP_REGISTER, 4'd3, 32'd0);
        plan_req(OP_REGISTER, 4'd10, 32'd0);
        plan_fixed(OP_CHECK, 4'd6, 32'd301, 3, 0, 0, 1, 1, 6, 1);
        plan_fixed(OP_CHECK, 4'd12, 32'd1000, 3, 0, 1, 1, 1, 9, 1);
        plan_req(OP_TOUCH, 4'd3, 32'h7FFF_FFFF);
        plan_req(OP_TOUCH, 4'd10, 32'h1234_5678);
        plan_cfg(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0);
        plan_req(OP_CHECK, 4'd0, 32'h8000_0000);
        plan_req(OP_UNREGISTER, 4'd0, 32'd0);
        plan_req(OP_CHECK, 4'd15, 32'd0);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                apply_limits(plan[i].lims);
            else
                send_req(plan[i].w, plan[i].fixed, plan[i].r);
        end

        for (int phase = 0; phase < 6; phase++)
        begin
            lims[0] = pick_limit(600);
            lims[1] = pick_limit(3000);
            lims[2] = pick_limit(20000);
            lims[3] = pick_limit(20000);
            apply_limits(lims);
            calm = (phase == 5);
            wall = $urandom;
            repeat (160)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 25)
                    w.req_type = OP_REGISTER;
                else if (roll < 60)
                    w.req_type = OP_TOUCH;
                else if (roll < 70)
                    w.req_type = OP_UNREGISTER;
                else
                    w.req_type = OP_CHECK;
                w.slot = SLOT_FIELD_W'($urandom_range(0, WDM_MAX_SLOTS - 1));
                wall += $urandom_range(0, 400);
                w.now_time = ($urandom_range(0, 11) == 0) ? 32'($urandom) : wall;
                send_req(w, 1'b0, '0);
            end
        end

        settle();
        repeat (20) @(posedge clk);
        $display("%0d request words (%0d checks) over %0d limit settings",
                 n_words, n_checks, n_settings);
        $display("%0d results raised kill, %0d raised multi-kill", n_kill, n_multi);
        if (errors == 0)
            $display("multi_thread_watchdog_monitor test passed");
        else
            $display("multi_thread_watchdog_monitor test failed");
        $finish;
    end

    initial
    begin : drain_side
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            pop <= 1'b1;
        end
    end

    initial
    begin : watchdog_timer
        #10_000_000;
        $display("timeout with %0d results outstanding", expected_q.size());
        $display("multi_thread_watchdog_monitor test failed");
        $finish;
    end

endmodule
